/* hw/rtl/sorted_key_table_lookup_top_assert.svh */
// Assertion macros shared by the sorted key table checker.
// No dependencies; include once per file that asserts.
`ifndef SORTED_KEY_TABLE_LOOKUP_TOP_ASSERT_SVH
`define SORTED_KEY_TABLE_LOOKUP_TOP_ASSERT_SVH

// same-cycle implication, disabled in reset
`define SKTL_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define SKTL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/sktl_pkg.sv */
// Shared widths, command codes and cell control type for the sorted key table.
// No dependencies.
`default_nettype none

package sktl_pkg;

   localparam int KEY_W     = 64;
   localparam int CMD_W     = 2;
   localparam int ENTRIES_W = 9;
   localparam int DEPTH_DEF = 256;

   localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic             load;    // item accepted this cycle
      logic             ins_en;  // insert with room left
      logic             lookup;  // lookup item
      logic [KEY_W-1:0] key;     // request key
   } cell_ctrl_type;

endpackage

`default_nettype wire

/* hw/rtl/sorted_key_table_lookup_top.sv */
// Sorted key table: chain of compare-and-shift cells plus a result stage.
// Depends on sktl_pkg and sktl_cell.
//
//   channel | ports                                   | direction
//   req     | req_valid/ready, cmd, key, want_key     | in
//   rsp     | rsp_valid/ready, accepted, found,       | out
//           | matched_key, entries                    |
//
// Every item is taken as a whole: insert, lookup and clear all act on the
// whole chain at once, each cell comparing its key against the request key.
// A lookup's per-cell hits are registered, then ORed into the output register
// once it is free, so throughput is one per cycle unless the output stalls.
// The output register holds while rsp_ready is low; req_ready drops only when
// both the hit stage and the output register are full and rsp_ready is low.
// Reset empties the table at once by clearing the count; cell contents are kept.
`default_nettype none

module sorted_key_table_lookup_top
   import sktl_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [CMD_W-1:0]     req_cmd,
   input  wire logic [KEY_W-1:0]     req_key,
   input  wire logic                 req_want_key,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_accepted,
   output logic                      rsp_found,
   output logic      [KEY_W-1:0]     rsp_matched_key,
   output logic      [ENTRIES_W-1:0] rsp_entries
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             accept, full, s1_move, out_free;
   cell_ctrl_type    ctrl;

   logic [KEY_W-1:0] cell_key   [DEPTH];
   logic             cell_after [DEPTH];
   logic [DEPTH-1:0] hit_vec;

   // hit stage
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_lookup_ff, s1_want_ff, s1_acc_ff;
   logic [KEY_W-1:0]     s1_key_ff;
   logic [ENTRIES_W-1:0] s1_entries_ff;

   // output register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_acc_ff, rsp_found_ff, s1_found;
   logic [KEY_W-1:0]     rsp_key_ff;
   logic [ENTRIES_W-1:0] rsp_entries_ff;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_ready = !s1_valid_ff || out_free;
   assign accept    = req_valid && req_ready;
   assign full      = count_ff == FULL;

   assign ctrl.load   = accept;
   assign ctrl.ins_en = accept && (req_cmd == CMD_INSERT) && !full;
   assign ctrl.lookup = req_cmd == CMD_LOOKUP;
   assign ctrl.key    = req_key;

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins_en) begin
         count_in = count_ff + 1'b1;
      end else if (accept && (req_cmd == CMD_CLEAR)) begin
         count_in = '0;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic             p_after;
      logic [KEY_W-1:0] p_key;
      if (i == 0) begin : g_head
         assign p_after = 1'b0;
         assign p_key   = '0;
      end else begin : g_link
         assign p_after = cell_after[i-1];
         assign p_key   = cell_key[i-1];
      end
      sktl_cell #(
         .CNT_W    (CNT_W),
         .CELL_IDX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .prev_after (p_after),
         .prev_key   (p_key),
         .after      (cell_after[i]),
         .key_out    (cell_key[i]),
         .hit        (hit_vec[i])
      );
   end

   assign s1_found     = s1_lookup_ff && (|hit_vec);
   assign s1_valid_in  = accept || (s1_valid_ff && !s1_move);
   assign rsp_valid_in = s1_move || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_lookup_ff  <= ctrl.lookup;
         s1_want_ff    <= req_want_key;
         s1_key_ff     <= req_key;
         s1_acc_ff     <= ctrl.ins_en || (req_cmd == CMD_CLEAR);
         s1_entries_ff <= ENTRIES_W'(count_in);
      end
      if (s1_move) begin
         rsp_acc_ff     <= s1_acc_ff;
         rsp_found_ff   <= s1_found;
         rsp_key_ff     <= (s1_found && s1_want_ff) ? s1_key_ff : '0;
         rsp_entries_ff <= s1_entries_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accepted    = rsp_acc_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_matched_key = rsp_key_ff;
   assign rsp_entries     = rsp_entries_ff;

endmodule

`default_nettype wire

/* hw/rtl/sktl_cell.sv */
// One slot of the sorted key chain: holds a key, compares it against the
// broadcast request, shifts up on insert. Depends on sktl_pkg.
`default_nettype none

module sktl_cell
   import sktl_pkg::*;
#(
   parameter int CNT_W    = 9,
   parameter int CELL_IDX = 0
) (
   input  wire logic             clock,
   input  wire cell_ctrl_type    ctrl,
   input  wire logic [CNT_W-1:0] count,
   input  wire logic             prev_after,
   input  wire logic [KEY_W-1:0] prev_key,
   output logic                  after,
   output logic      [KEY_W-1:0] key_out,
   output logic                  hit
);

   localparam logic [CNT_W-1:0] IDX = CNT_W'(CELL_IDX);

   logic [KEY_W-1:0] key_ff, key_in;
   logic             hit_ff, hit_in;
   logic             occupied;

   assign occupied = IDX < count;
   // slot lies at or past the insert point (empty slots always do)
   assign after    = !occupied || (key_ff > ctrl.key);

   always_comb begin
      key_in = key_ff;
      if (ctrl.ins_en) begin
         if (prev_after) begin
            key_in = prev_key;
         end else if (after) begin
            key_in = ctrl.key;
         end
      end
      hit_in = ctrl.lookup && occupied && (key_ff == ctrl.key);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         key_ff <= key_in;
         hit_ff <= hit_in;
      end
   end

   assign key_out = key_ff;
   assign hit     = hit_ff;

endmodule

`default_nettype wire

/* hw/rtl/sktl_checker.sv */
// Port-level checks for the sorted key table, bound to the top level.
// Depends on sktl_pkg and sorted_key_table_lookup_top_assert.svh.
`default_nettype none

`include "sorted_key_table_lookup_top_assert.svh"

module sktl_checker
   import sktl_pkg::*;
(
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_valid,
   input wire logic                 req_ready,
   input wire logic [CMD_W-1:0]     req_cmd,
   input wire logic [KEY_W-1:0]     req_key,
   input wire logic                 req_want_key,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_ready,
   input wire logic                 rsp_accepted,
   input wire logic                 rsp_found,
   input wire logic [KEY_W-1:0]     rsp_matched_key,
   input wire logic [ENTRIES_W-1:0] rsp_entries
);

   logic                         req_stall, rsp_stall, rsp_hit, rsp_miss;
   logic [CMD_W+KEY_W:0]         req_item;
   logic [KEY_W+ENTRIES_W+1:0]   rsp_item;

   assign req_stall = req_valid && !req_ready;
   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_hit   = rsp_valid && rsp_found;
   assign rsp_miss  = rsp_valid && !rsp_found;
   assign req_item  = {req_cmd, req_key, req_want_key};
   assign rsp_item  = {rsp_accepted, rsp_found, rsp_matched_key, rsp_entries};

   // stalled req item must hold
   `SKTL_ASSERT_NEXT(a_req_hold, clock, reset, req_stall, req_valid && $stable(req_item), "req changed")

   // stalled rsp item must hold
   `SKTL_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_item), "rsp changed")

   // a lookup hit never reports a completed insert or clear
   `SKTL_ASSERT_NOW(a_found_excl, clock, reset, rsp_hit, !rsp_accepted, "found with accepted")

   // matched key only appears on a hit
   `SKTL_ASSERT_NOW(a_miss_zero, clock, reset, rsp_miss, rsp_matched_key == '0, "key on a miss")

   // no result leaves in the cycle after reset
   `SKTL_ASSERT_NOW(a_reset_quiet, clock, reset, $past(reset), !rsp_valid, "valid after reset")

endmodule

bind sorted_key_table_lookup_top sktl_checker u_sktl_checker (.*);

`default_nettype wire
